// ===== hw/rtl/utsf_pkg.sv =====
// Shared constants, types and helpers for the UART transmit serialiser with FIFO.
package utsf_pkg;

  localparam int unsigned FIFO_DEPTH = 256;
  localparam int unsigned DATA_BITS  = 8;
  localparam int unsigned CMDQ_DEPTH = 2;

  localparam int unsigned PTR_W   = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W   = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned POS_W   = $clog2(DATA_BITS + 2);
  localparam int unsigned BIT_W   = (DATA_BITS > 1) ? $clog2(DATA_BITS) : 1;
  localparam int unsigned CQPTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int unsigned CQCNT_W = $clog2(CMDQ_DEPTH + 1);
  localparam int unsigned PER_W   = 16;

  localparam logic [PER_W-1:0] PERIOD_RST  = PER_W'(434);
  localparam logic [CNT_W-1:0] FIFO_FULL_N = CNT_W'(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST    = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [POS_W-1:0] POS_IDLE    = '0;
  localparam logic [POS_W-1:0] POS_LAST    = POS_W'(DATA_BITS);

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_ENQ  = 1'b1
  } utsf_op_e;

  typedef struct packed {
    utsf_op_e             op;
    logic [DATA_BITS-1:0] data;
  } utsf_cmd_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_LAST) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/utsf_front.sv =====
// Input stage: accept beats, classify them into commands and hand them to the queue.
module utsf_front import utsf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 op_i,
  input  logic [DATA_BITS-1:0] data_byte_i,
  output logic                 push_o,
  output utsf_cmd_t            cmd_o,
  input  logic                 q_full_i
);

  logic      valid_q, valid_d;
  utsf_cmd_t cmd_q;
  logic      accept;

  assign in_stall_o = valid_q && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = valid_q && !q_full_i;
  assign cmd_o      = cmd_q;
  assign valid_d    = accept || (valid_q && !push_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q.op   <= utsf_op_e'(op_i);
      cmd_q.data <= data_byte_i;
    end
  end

endmodule

// ===== hw/rtl/utsf_cmd_queue.sv =====
// Short command queue between the input stage and the transmit engine.
module utsf_cmd_queue import utsf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  utsf_cmd_t cmd_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output utsf_cmd_t cmd_o
);

  localparam logic [CQPTR_W-1:0] CQ_LAST = CQPTR_W'(CMDQ_DEPTH - 1);
  localparam logic [CQCNT_W-1:0] CQ_FULL = CQCNT_W'(CMDQ_DEPTH);

  utsf_cmd_t          slot_q [CMDQ_DEPTH];
  logic [CQPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CQCNT_W-1:0] cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CQ_FULL);
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == CQ_LAST) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == CQ_LAST) ? '0 : rd_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

endmodule

// ===== hw/rtl/utsf_back.sv =====
// Transmit engine: byte FIFO, bit-period timer, 8N1 framing and result register.
module utsf_back import utsf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  input  utsf_cmd_t            cmd_i,
  output logic                 pop_o,
  input  logic                 cfg_we_i,
  input  logic [PER_W-1:0]     cfg_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 tx_line_o,
  output logic                 byte_accepted_o,
  output logic [CNT_W-1:0]     queue_level_o,
  output logic                 bit_edge_o
);

  logic [DATA_BITS-1:0] mem_q [FIFO_DEPTH];
  logic [DATA_BITS-1:0] rd_data_q;

  logic [PER_W-1:0]     period_q;
  logic [PTR_W-1:0]     head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [POS_W-1:0]     pos_q, pos_d, pos_m1;
  logic [DATA_BITS-1:0] shift_q, shift_d, shift_eff;
  logic                 load_q, run_q, run_d, line_q, line_d;
  logic [PER_W-1:0]     cd_q, cd_d;

  logic                 out_valid_q;
  logic                 tx_q, acc_q, edge_q;
  logic [CNT_W-1:0]     lvl_q;

  logic                 go, wr_en, rd_en, acc, edge_hit, restart;

  assign go        = cmd_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o     = go;
  assign shift_eff = load_q ? rd_data_q : shift_q;
  assign pos_m1    = pos_q - 1'b1;

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    pos_d    = pos_q;
    shift_d  = shift_eff;
    run_d    = run_q;
    cd_d     = cd_q;
    line_d   = line_q;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    acc      = 1'b0;
    edge_hit = 1'b0;
    restart  = 1'b0;
    if (go) begin
      if (cmd_i.op == OP_ENQ) begin
        if (count_q < FIFO_FULL_N) begin
          wr_en   = 1'b1;
          tail_d  = ptr_inc(tail_q);
          count_d = count_q + 1'b1;
          acc     = 1'b1;
        end
        if (!run_q) begin
          run_d = 1'b1;
          cd_d  = period_q;
        end
      end else if (run_q) begin
        if (cd_q <= PER_W'(1)) begin
          edge_hit = 1'b1;
          if (pos_q == POS_IDLE) begin
            if (count_q != '0) begin
              rd_en   = 1'b1;
              head_d  = ptr_inc(head_q);
              count_d = count_q - 1'b1;
              line_d  = 1'b0;
              pos_d   = POS_W'(1);
              restart = 1'b1;
            end
          end else if (pos_q <= POS_LAST) begin
            line_d  = shift_eff[pos_m1[BIT_W-1:0]];
            pos_d   = pos_q + 1'b1;
            restart = 1'b1;
          end else begin
            line_d  = 1'b1;
            shift_d = '0;
            pos_d   = POS_IDLE;
            restart = (count_q != '0);
          end
          run_d = restart;
          cd_d  = restart ? period_q : '0;
        end else begin
          cd_d = cd_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= PERIOD_RST;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      pos_q       <= POS_IDLE;
      shift_q     <= '0;
      load_q      <= 1'b0;
      run_q       <= 1'b0;
      cd_q        <= '0;
      line_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        period_q <= cfg_data_i;
      end
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      pos_q   <= pos_d;
      shift_q <= shift_d;
      load_q  <= rd_en;
      run_q   <= run_d;
      cd_q    <= cd_d;
      line_q  <= line_d;
      if (go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[tail_q] <= cmd_i.data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[head_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      tx_q   <= line_d;
      acc_q  <= acc;
      lvl_q  <= count_d;
      edge_q <= edge_hit;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign tx_line_o       = tx_q;
  assign byte_accepted_o = acc_q;
  assign queue_level_o   = lvl_q;
  assign bit_edge_o      = edge_q;

endmodule

// ===== hw/rtl/uart_tx_serializer_fifo_top.sv =====
// Top level of the 8N1 UART transmitter with a 256-byte transmit FIFO.
// Each input beat is either one clock tick (op 0) or a byte to enqueue (op 1); every
// input beat yields exactly one result beat with the line level, enqueue outcome, FIFO
// level and bit-edge flag after that beat. One beat is taken per clock when the result
// side does not stall; a beat's result passes through the input register, the two-entry
// command queue and the result register. The bit period is written on the configuration
// channel, which is always ready, and must only be changed while idle.
module uart_tx_serializer_fifo_top import utsf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [PER_W-1:0]     cfg_bit_period_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 op_i,
  input  logic [DATA_BITS-1:0] data_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 tx_line_o,
  output logic                 byte_accepted_o,
  output logic [CNT_W-1:0]     queue_level_o,
  output logic                 bit_edge_o
);

  logic      push, q_full, q_valid, pop;
  utsf_cmd_t front_cmd, q_cmd;

  assign cfg_ready_o = 1'b1;

  utsf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .data_byte_i (data_byte_i),
    .push_o      (push),
    .cmd_o       (front_cmd),
    .q_full_i    (q_full)
  );

  utsf_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  utsf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (q_valid),
    .cmd_i           (q_cmd),
    .pop_o           (pop),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_data_i      (cfg_bit_period_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .tx_line_o       (tx_line_o),
    .byte_accepted_o (byte_accepted_o),
    .queue_level_o   (queue_level_o),
    .bit_edge_o      (bit_edge_o)
  );

endmodule

// ===== hw/rtl/utsf_checker.sv =====
// Port-level checks on the UART transmitter, bound to the top level.
module utsf_checker import utsf_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic                 tx_line_o,
  input logic                 byte_accepted_o,
  input logic [CNT_W-1:0]     queue_level_o,
  input logic                 bit_edge_o
);

  a_edge_xor_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(byte_accepted_o && bit_edge_o))
    else $error("enqueue and bit edge reported on one beat");

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (queue_level_o <= FIFO_FULL_N))
    else $error("queue level beyond FIFO depth");

  a_accept_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && byte_accepted_o) |-> (queue_level_o != '0))
    else $error("accepted byte with empty FIFO");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(tx_line_o) && $stable(queue_level_o)
       && $stable(byte_accepted_o) && $stable(bit_edge_o)))
    else $error("stalled result beat changed");

endmodule

bind uart_tx_serializer_fifo_top utsf_checker u_checker (.*);

// ===== dv/tb.sv =====
// Testbench for the UART transmit serialiser with FIFO, checked beat by beat against a predictor.
`timescale 1ns / 1ps

module tb;
  import utsf_pkg::*;

  typedef struct packed {
    logic             tx_line;
    logic             byte_accepted;
    logic [CNT_W-1:0] queue_level;
    logic             bit_edge;
  } line_beat_t;

  typedef struct {
    utsf_op_e             op;
    logic [DATA_BITS-1:0] data;
    bit                   typed;
    line_beat_t           want;
  } stim_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [PER_W-1:0]     cfg_bit_period_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 op_i = 1'b0;
  logic [DATA_BITS-1:0] data_byte_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 tx_line_o;
  logic                 byte_accepted_o;
  logic [CNT_W-1:0]     queue_level_o;
  logic                 bit_edge_o;

  // predictor state
  logic [DATA_BITS-1:0] fifo_mem [FIFO_DEPTH];
  logic [PTR_W-1:0]     rd_ptr = '0;
  logic [PTR_W-1:0]     wr_ptr = '0;
  logic [CNT_W-1:0]     fill = '0;
  int unsigned          frame_pos = 0;
  logic [DATA_BITS-1:0] shreg = '0;
  bit                   tmr_on = 1'b0;
  logic [PER_W-1:0]     countdown = '0;
  logic [PER_W-1:0]     period_q = PERIOD_RST;
  logic                 line_q = 1'b1;

  line_beat_t  line_beats_due[$];
  stim_row_t   dir_rows[$];
  int unsigned fails = 0;
  bit          pacing = 1'b1;
  logic        park_armed = 1'b0;

  uart_tx_serializer_fifo_top u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_bit_period_i (cfg_bit_period_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .data_byte_i      (data_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .tx_line_o        (tx_line_o),
    .byte_accepted_o  (byte_accepted_o),
    .queue_level_o    (queue_level_o),
    .bit_edge_o       (bit_edge_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic line_beat_t tx_step(utsf_op_e op, logic [DATA_BITS-1:0] data);
    line_beat_t r;
    bit         restart;
    r.byte_accepted = 1'b0;
    r.bit_edge      = 1'b0;
    restart         = 1'b0;
    if (op == OP_ENQ) begin
      if (fill < FIFO_FULL_N) begin
        fifo_mem[wr_ptr] = data;
        wr_ptr = wr_ptr + 1'b1;
        fill = fill + 1'b1;
        r.byte_accepted = 1'b1;
      end
      if (!tmr_on) begin
        tmr_on    = 1'b1;
        countdown = period_q;
      end
    end else if (tmr_on) begin
      if (countdown <= 1) begin
        r.bit_edge = 1'b1;
        if (frame_pos == 0) begin
          if (fill != 0) begin
            shreg = fifo_mem[rd_ptr];
            rd_ptr = rd_ptr + 1'b1;
            fill = fill - 1'b1;
            line_q = 1'b0;
            frame_pos = 1;
            restart = 1'b1;
          end
        end else if (frame_pos <= DATA_BITS) begin
          line_q = shreg[frame_pos-1];
          frame_pos++;
          restart = 1'b1;
        end else begin
          line_q = 1'b1;
          shreg = '0;
          frame_pos = 0;
          restart = (fill != 0);
        end
        tmr_on    = restart;
        countdown = restart ? period_q : '0;
      end else begin
        countdown = countdown - 1'b1;
      end
    end
    r.tx_line     = line_q;
    r.queue_level = fill;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!pacing || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic stim_row_t row(utsf_op_e op, logic [DATA_BITS-1:0] data, bit typed,
                                    logic ln, logic acc, int unsigned lvl, logic be);
    stim_row_t r;
    r.op   = op;
    r.data = data;
    r.typed = typed;
    r.want = '{tx_line: ln, byte_accepted: acc, queue_level: CNT_W'(lvl), bit_edge: be};
    return r;
  endfunction

  task automatic send_beat(utsf_op_e op, logic [DATA_BITS-1:0] data, bit typed,
                           line_beat_t want);
    int unsigned gap;
    line_beat_t  pred;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    op_i        <= op;
    data_byte_i <= data;
    do @(posedge clk_i); while (in_stall_o);
    pred = tx_step(op, data);
    line_beats_due.push_back(typed ? want : pred);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (line_beats_due.size() != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_period(logic [PER_W-1:0] value);
    cfg_valid_i      <= 1'b1;
    cfg_bit_period_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    period_q = value;
  endtask

  task automatic run_phase(logic [PER_W-1:0] value, int unsigned beats, int unsigned enq_pct);
    utsf_op_e             op;
    logic [DATA_BITS-1:0] data;
    int unsigned          roll;
    write_period(value);
    for (int unsigned n = 0; n < beats; n++) begin
      op   = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_TICK;
      roll = $urandom_range(0, 15);
      data = (roll == 0) ? '0 : (roll == 1) ? '1 : DATA_BITS'($urandom_range(0, 255));
      send_beat(op, data, 1'b0, '0);
    end
    settle();
  endtask

  // result side: random stalls, plus one long hold when armed
  initial begin : rx_side
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold != 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if (park_armed) begin
          park_armed <= 1'b0;
          hold = 150;
        end else if ($urandom_range(0, 7) == 0) begin
          hold = pick_gap();
        end
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    line_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (line_beats_due.size() == 0) begin
        $error("result beat with nothing expected");
        fails++;
      end else begin
        want = line_beats_due.pop_front();
        if (tx_line_o !== want.tx_line) begin
          $error("tx_line: expected %0b, got %0b", want.tx_line, tx_line_o);
          fails++;
        end
        if (byte_accepted_o !== want.byte_accepted) begin
          $error("byte_accepted: expected %0b, got %0b", want.byte_accepted, byte_accepted_o);
          fails++;
        end
        if (queue_level_o !== want.queue_level) begin
          $error("queue_level: expected %0d, got %0d", want.queue_level, queue_level_o);
          fails++;
        end
        if (bit_edge_o !== want.bit_edge) begin
          $error("bit_edge: expected %0b, got %0b", want.bit_edge, bit_edge_o);
          fails++;
        end
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("uart_tx_serializer_fifo_top regression: fail");
    $finish;
  end

  initial begin : main_seq
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one bit per tick: a whole frame of ones, then three bytes queued back to back
    dir_rows.push_back(row(OP_TICK, 8'h00, 1, 1'b1, 1'b0, 0, 1'b0));
    dir_rows.push_back(row(OP_ENQ,  8'hFF, 1, 1'b1, 1'b1, 1, 1'b0));
    dir_rows.push_back(row(OP_TICK, 8'h00, 1, 1'b0, 1'b0, 0, 1'b1));
    for (int i = 0; i < DATA_BITS; i++)
      dir_rows.push_back(row(OP_TICK, 8'h00, 1, 1'b1, 1'b0, 0, 1'b1));
    dir_rows.push_back(row(OP_TICK, 8'h00, 1, 1'b1, 1'b0, 0, 1'b1));
    dir_rows.push_back(row(OP_TICK, 8'hFF, 1, 1'b1, 1'b0, 0, 1'b0));
    dir_rows.push_back(row(OP_ENQ,  8'h00, 1, 1'b1, 1'b1, 1, 1'b0));
    dir_rows.push_back(row(OP_ENQ,  8'hA5, 0, 1'b0, 1'b0, 0, 1'b0));
    dir_rows.push_back(row(OP_ENQ,  8'h5A, 0, 1'b0, 1'b0, 0, 1'b0));
    for (int i = 0; i < 7; i++)
      dir_rows.push_back(row(OP_TICK, 8'h00, 0, 1'b0, 1'b0, 0, 1'b0));

    write_period(PER_W'(1));
    foreach (dir_rows[i])
      send_beat(dir_rows[i].op, dir_rows[i].data, dir_rows[i].typed, dir_rows[i].want);
    settle();

    run_phase(PER_W'(2), 90, 10);
    pacing = 1'b0;
    run_phase(PER_W'(1), 90, 12);
    pacing = 1'b1;
    run_phase(PER_W'(3), 90, 8);
    run_phase(PER_W'($urandom_range(4, 9)), 90, 10);
    run_phase(PER_W'(434), 30, 20);

    // slowest rate: flood the queue past full while the result side is parked
    park_armed <= 1'b1;
    run_phase(PER_W'(65535), 285, 93);

    if (fails == 0) begin
      $display("uart_tx_serializer_fifo_top regression: pass");
    end else begin
      $display("uart_tx_serializer_fifo_top regression: fail");
    end
    $finish;
  end

endmodule
